FILE: hw/rtl/itrn_pkg.sv
package itrn_pkg;

    // Largest number that has a Roman numeral in this block.
    localparam logic [11:0] MAX_VALUE = 12'd3999;

    // ASCII codes of the numeral letters.
    localparam logic [6:0] LETTER_I = 7'h49;
    localparam logic [6:0] LETTER_V = 7'h56;
    localparam logic [6:0] LETTER_X = 7'h58;
    localparam logic [6:0] LETTER_L = 7'h4C;
    localparam logic [6:0] LETTER_C = 7'h43;
    localparam logic [6:0] LETTER_D = 7'h44;
    localparam logic [6:0] LETTER_M = 7'h4D;
    localparam logic [6:0] LETTER_NONE = 7'h00;

    // Digit positions, most significant first.
    localparam logic [1:0] POS_THOUSANDS = 2'd0;
    localparam logic [1:0] POS_HUNDREDS = 2'd1;
    localparam logic [1:0] POS_TENS = 2'd2;
    localparam logic [1:0] POS_UNITS = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INVALID,
        S_EXTRACT,
        S_EMIT
    } t_state;

    // Place value subtracted at each position during digit extraction.
    function automatic logic [10:0] place_weight(input logic [1:0] pos);
        logic [10:0] w;
        unique case (pos)
            POS_THOUSANDS: w = 11'd1000;
            POS_HUNDREDS:  w = 11'd100;
            POS_TENS:      w = 11'd10;
            default:       w = 11'd1;
        endcase
        return w;
    endfunction

    // Number of letters one decimal digit produces.
    function automatic logic [2:0] digit_len(input logic [3:0] d);
        logic [2:0] n;
        if (d == 4'd0) begin
            n = 3'd0;
        end else if (d == 4'd4 || d == 4'd9) begin
            n = 3'd2;
        end else if (d >= 4'd5) begin
            n = 3'(d - 4'd4);
        end else begin
            n = d[2:0];
        end
        return n;
    endfunction

    function automatic logic [6:0] sym_one(input logic [1:0] pos);
        logic [6:0] c;
        unique case (pos)
            POS_THOUSANDS: c = LETTER_M;
            POS_HUNDREDS:  c = LETTER_C;
            POS_TENS:      c = LETTER_X;
            default:       c = LETTER_I;
        endcase
        return c;
    endfunction

    function automatic logic [6:0] sym_five(input logic [1:0] pos);
        logic [6:0] c;
        unique case (pos)
            POS_THOUSANDS: c = LETTER_NONE;
            POS_HUNDREDS:  c = LETTER_D;
            POS_TENS:      c = LETTER_L;
            default:       c = LETTER_V;
        endcase
        return c;
    endfunction

    function automatic logic [6:0] sym_ten(input logic [1:0] pos);
        logic [6:0] c;
        unique case (pos)
            POS_THOUSANDS: c = LETTER_NONE;
            POS_HUNDREDS:  c = LETTER_M;
            POS_TENS:      c = LETTER_C;
            default:       c = LETTER_X;
        endcase
        return c;
    endfunction

    // Letter number idx of the numeral for digit d at position pos.
    function automatic logic [6:0] digit_letter(input logic [1:0] pos, input logic [3:0] d,
                                                input logic [2:0] idx);
        logic [6:0] c;
        if (d == 4'd4) begin
            c = (idx == 3'd0) ? sym_one(pos) : sym_five(pos);
        end else if (d == 4'd9) begin
            c = (idx == 3'd0) ? sym_one(pos) : sym_ten(pos);
        end else if (d >= 4'd5 && idx == 3'd0) begin
            c = sym_five(pos);
        end else begin
            c = sym_one(pos);
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/integer_to_roman_numeral_core.sv
// Converts a binary number from 1 to 3999 into its Roman numeral, one ASCII letter
// per output transfer, thousands first; the final letter carries o_last. An input of 0
// or above 3999 gives a single transfer with o_letter 0, o_last 1 and o_invalid 1.
// One number is handled at a time: o_in_ready is high only while idle. A single
// 13-bit subtract-and-compare unit extracts the decimal digits by repeated subtraction
// of 1000, 100 and 10; the units digit is what remains. Emission then gives the
// letters in order, at most 15 of them, waiting whenever the output side stalls, and
// zero digits give no letter. Of valid numbers, 3888 keeps the block busy longest; an
// invalid input goes from idle to S_INVALID, which loads its transfer once the output
// register is free and then returns to idle. The output register lets the next number
// be taken while the last letter still waits.
module integer_to_roman_numeral_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [11:0] i_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [6:0]  o_letter,
    output logic        o_last,
    output logic        o_invalid
);

    itrn_pkg::t_state r_state, n_state;

    logic [11:0] r_rem, n_rem;
    logic [3:0]  r_digits [4];
    logic [3:0]  n_digits [4];
    logic [1:0]  r_pos, n_pos;
    logic [2:0]  r_idx, n_idx;
    logic        r_out_valid, n_out_valid;
    logic [6:0]  r_letter, n_letter;
    logic        r_last, n_last;
    logic        r_invalid, n_invalid;

    logic        w_accept;
    logic        w_bad_value;
    logic        w_slot_free;
    logic [12:0] w_diff;
    logic        w_borrow;
    logic [3:0]  w_digit;
    logic [2:0]  w_len;
    logic        w_digit_done;
    logic        w_rest_zero;

    // Handshake and input range check.
    assign o_in_ready  = (r_state == itrn_pkg::S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_bad_value = (i_value == 12'd0) || (i_value > itrn_pkg::MAX_VALUE);
    assign w_slot_free = !r_out_valid || i_out_ready;

    // Shared subtract-and-compare unit used for digit extraction.
    assign w_diff   = {1'b0, r_rem} - {2'b00, itrn_pkg::place_weight(r_pos)};
    assign w_borrow = w_diff[12];

    // Current digit being emitted and its letter count.
    assign w_digit      = r_digits[r_pos];
    assign w_len        = itrn_pkg::digit_len(w_digit);
    assign w_digit_done = (r_idx == 3'(w_len - 3'd1));

    // True when every digit after the current one is zero.
    always_comb begin
        w_rest_zero = 1'b1;
        for (int j = 0; j < 4; j++) begin
            if (2'(j) > r_pos && r_digits[j] != 4'd0) begin
                w_rest_zero = 1'b0;
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            itrn_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = w_bad_value ? itrn_pkg::S_INVALID : itrn_pkg::S_EXTRACT;
                end
            end
            itrn_pkg::S_INVALID: begin
                if (w_slot_free) begin
                    n_state = itrn_pkg::S_IDLE;
                end
            end
            itrn_pkg::S_EXTRACT: begin
                if (w_borrow && r_pos == itrn_pkg::POS_TENS) begin
                    n_state = itrn_pkg::S_EMIT;
                end
            end
            itrn_pkg::S_EMIT: begin
                if (r_pos == itrn_pkg::POS_UNITS &&
                    (w_len == 3'd0 || (w_slot_free && w_digit_done))) begin
                    n_state = itrn_pkg::S_IDLE;
                end
            end
            default: n_state = itrn_pkg::S_IDLE;
        endcase
    end

    // Datapath and output register updates.
    always_comb begin
        n_rem       = r_rem;
        n_digits    = r_digits;
        n_pos       = r_pos;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_letter    = r_letter;
        n_last      = r_last;
        n_invalid   = r_invalid;
        unique case (r_state)
            itrn_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_rem = i_value;
                    for (int j = 0; j < 4; j++) begin
                        n_digits[j] = 4'd0;
                    end
                    n_pos = itrn_pkg::POS_THOUSANDS;
                    n_idx = 3'd0;
                end
            end
            itrn_pkg::S_INVALID: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_letter    = itrn_pkg::LETTER_NONE;
                    n_last      = 1'b1;
                    n_invalid   = 1'b1;
                end
            end
            itrn_pkg::S_EXTRACT: begin
                if (!w_borrow) begin
                    n_rem           = w_diff[11:0];
                    n_digits[r_pos] = r_digits[r_pos] + 4'd1;
                end else if (r_pos == itrn_pkg::POS_TENS) begin
                    n_digits[itrn_pkg::POS_UNITS] = r_rem[3:0];
                    n_pos = itrn_pkg::POS_THOUSANDS;
                    n_idx = 3'd0;
                end else begin
                    n_pos = r_pos + 2'd1;
                end
            end
            itrn_pkg::S_EMIT: begin
                if (w_len == 3'd0) begin
                    n_pos = r_pos + 2'd1;
                    n_idx = 3'd0;
                end else if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_letter    = itrn_pkg::digit_letter(r_pos, w_digit, r_idx);
                    n_last      = w_digit_done && w_rest_zero;
                    n_invalid   = 1'b0;
                    if (w_digit_done) begin
                        n_pos = r_pos + 2'd1;
                        n_idx = 3'd0;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= itrn_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_rem     <= n_rem;
        r_digits  <= n_digits;
        r_pos     <= n_pos;
        r_idx     <= n_idx;
        r_letter  <= n_letter;
        r_last    <= n_last;
        r_invalid <= n_invalid;
    end

    assign o_out_valid = r_out_valid;
    assign o_letter    = r_letter;
    assign o_last      = r_last;
    assign o_invalid   = r_invalid;

endmodule

FILE: tb/sv/integer_to_roman_numeral_core_tb.sv
`timescale 1ns / 1ps

module integer_to_roman_numeral_core_tb;

    // Cycles without any transfer before the run is declared hung.
    localparam int unsigned STALL_LIMIT = 2000;
    // Length of the long receiver hold-off.
    localparam int unsigned HOLD_OFF_CYCLES = 200;
    // Quiet cycles watched for stray letters once everything has arrived.
    localparam int unsigned TAIL_CYCLES = 40;
    localparam int unsigned MAX_REPORTS = 10;

    typedef struct packed {
        logic [6:0] letter;
        logic       last;
        logic       invalid;
    } t_numeral_letter;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [11:0] i_value;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [6:0]  o_letter;
    logic        o_last;
    logic        o_invalid;

    // Letters still owed by the block, oldest first.
    t_numeral_letter numeral_letters_q[$];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned ready_hold_cycles;
    int unsigned mismatch_count;
    int unsigned numbers_sent;
    int unsigned out_of_range_sent;
    int unsigned letters_checked;
    int unsigned longest_numeral;

    integer_to_roman_numeral_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_letter    (o_letter),
        .o_last      (o_last),
        .o_invalid   (o_invalid)
    );

    // Free-running 100 MHz clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void push_letter(input logic [6:0] letter);
        t_numeral_letter item;
        item.letter  = letter;
        item.last    = 1'b0;
        item.invalid = 1'b0;
        numeral_letters_q.push_back(item);
    endfunction

    // Expands one number into the letters of its numeral, thousands first.
    function automatic void predict_numeral(input logic [11:0] value);
        t_numeral_letter item;
        int unsigned     rest;
        int unsigned     weight;
        int unsigned     first_idx;
        int unsigned     ones;
        int              pos;
        logic [3:0]      digit;
        logic [6:0]      one_sym;
        logic [6:0]      five_sym;
        logic [6:0]      ten_sym;

        if (value == 12'd0 || value > itrn_pkg::MAX_VALUE) begin
            item.letter  = itrn_pkg::LETTER_NONE;
            item.last    = 1'b1;
            item.invalid = 1'b1;
            numeral_letters_q.push_back(item);
            out_of_range_sent++;
            return;
        end

        first_idx = numeral_letters_q.size();
        rest      = value;
        weight    = 1000;
        for (pos = 0; pos < 4; pos++) begin
            digit  = 4'(rest / weight);
            rest   = rest % weight;
            weight = weight / 10;
            case (pos)
                itrn_pkg::POS_THOUSANDS: begin
                    one_sym  = itrn_pkg::LETTER_M;
                    five_sym = itrn_pkg::LETTER_NONE;
                    ten_sym  = itrn_pkg::LETTER_NONE;
                end
                itrn_pkg::POS_HUNDREDS: begin
                    one_sym  = itrn_pkg::LETTER_C;
                    five_sym = itrn_pkg::LETTER_D;
                    ten_sym  = itrn_pkg::LETTER_M;
                end
                itrn_pkg::POS_TENS: begin
                    one_sym  = itrn_pkg::LETTER_X;
                    five_sym = itrn_pkg::LETTER_L;
                    ten_sym  = itrn_pkg::LETTER_C;
                end
                default: begin
                    one_sym  = itrn_pkg::LETTER_I;
                    five_sym = itrn_pkg::LETTER_V;
                    ten_sym  = itrn_pkg::LETTER_X;
                end
            endcase

            // Subtractive pairs first, then five-symbol plus ones.
            if (digit == 4'd4) begin
                push_letter(one_sym);
                push_letter(five_sym);
            end else if (digit == 4'd9) begin
                push_letter(one_sym);
                push_letter(ten_sym);
            end else begin
                ones = digit;
                if (digit >= 4'd5) begin
                    push_letter(five_sym);
                    ones = digit - 5;
                end
                repeat (ones) push_letter(one_sym);
            end
        end

        numeral_letters_q[numeral_letters_q.size() - 1].last = 1'b1;
        if (numeral_letters_q.size() - first_idx > longest_numeral) begin
            longest_numeral = numeral_letters_q.size() - first_idx;
        end
    endfunction

    // Offers one number after a random gap and records its letters once transferred.
    task automatic send_number(input logic [11:0] value);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= value;
        do @(posedge i_clk); while (!o_in_ready);
        predict_numeral(value);
        numbers_sent++;
    endtask

    // Withdraws the input and waits until every owed letter has been checked.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (numeral_letters_q.size() != 0) @(posedge i_clk);
    endtask

    // Edges of the range, every digit shape but 6 and 7, and the out-of-range values.
    task automatic test_directed_cases();
        logic [11:0] cases[$];
        cases = {12'd0, 12'd1, 12'd3, 12'd4, 12'd5, 12'd8, 12'd9, 12'd14, 12'd40,
                 12'd90, 12'd400, 12'd900, 12'd444, 12'd999, 12'd1000, 12'd2000,
                 12'd3000, 12'd1994, 12'd2048, 12'd3888, 12'd3999, 12'd4000,
                 12'd4095};
        send_idle_pct = 26;
        recv_idle_pct = 76;
        foreach (cases[i]) send_number(cases[i]);
        wait_for_drain();
    endtask

    // Mostly well-formed numbers, some built digit by digit, with a share out of range.
    task automatic test_random_numbers(input int unsigned count, input int unsigned send_pct,
                                       input int unsigned recv_pct);
        int unsigned sel;
        logic [11:0] value;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count) begin
            sel = $urandom_range(99);
            if (sel < 12) begin
                value = ($urandom_range(1) == 0) ? 12'd0 : 12'($urandom_range(4095, 4000));
            end else if (sel < 55) begin
                value = 12'($urandom_range(3) * 1000 + $urandom_range(9) * 100 +
                            $urandom_range(9) * 10 + $urandom_range(9));
            end else begin
                value = 12'($urandom_range(3999, 1));
            end
            send_number(value);
        end
        wait_for_drain();
    endtask

    // The receiver stops for a long stretch while the sender keeps offering numbers.
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        ready_hold_cycles = HOLD_OFF_CYCLES;
        send_number(12'd3888);
        repeat (5) send_number(12'($urandom_range(3999, 1)));
        wait_for_drain();
    endtask

    // Each number is sent only once the previous numeral has fully arrived.
    task automatic test_pause_until_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (4) begin
            send_number(12'($urandom_range(3999, 1)));
            wait_for_drain();
        end
    endtask

    // Receiver side: random stalls, or a long hold-off when one is requested.
    initial begin : out_ready_driver
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (ready_hold_cycles != 0) begin
                i_out_ready <= 1'b0;
                repeat (ready_hold_cycles) @(posedge i_clk);
                ready_hold_cycles = 0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Every output transfer is compared with the oldest owed letter.
    initial begin : letter_checker
        t_numeral_letter owed;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                letters_checked++;
                if (numeral_letters_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("%0t: unexpected letter %h last %b invalid %b", $realtime,
                                 o_letter, o_last, o_invalid);
                    end
                end else begin
                    owed = numeral_letters_q.pop_front();
                    if (o_letter !== owed.letter || o_last !== owed.last ||
                        o_invalid !== owed.invalid) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display("%0t: expected letter %h last %b invalid %b, got %h %b %b",
                                     $realtime, owed.letter, owed.last, owed.invalid,
                                     o_letter, o_last, o_invalid);
                        end
                    end
                end
            end
        end
    end

    // Ends the run if no transfer happens on either side for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("integer_to_roman_numeral_core_tb failed");
        $finish;
    end

    // Reset, then the tests in turn, then the final verdict.
    initial begin : test_sequence
        send_idle_pct     = 0;
        recv_idle_pct     = 0;
        ready_hold_cycles = 0;
        mismatch_count    = 0;
        numbers_sent      = 0;
        out_of_range_sent = 0;
        letters_checked   = 0;
        longest_numeral   = 0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_value    <= 12'd0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_random_numbers(23, 26, 76);
        test_random_numbers(22, 76, 26);
        test_random_numbers(22, 0, 0);
        test_output_backpressure();
        test_pause_until_drained();

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Converted %0d numbers, %0d of them out of range, into %0d checked letters.",
                 numbers_sent, out_of_range_sent, letters_checked);
        $display("Longest numeral %0d letters; %0d mismatches; both sides stalled and held off.",
                 longest_numeral, mismatch_count);
        if (mismatch_count == 0 && numeral_letters_q.size() == 0) begin
            $display("integer_to_roman_numeral_core_tb passed");
        end else begin
            $display("integer_to_roman_numeral_core_tb failed");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/itrn_pkg.sv
hw/rtl/integer_to_roman_numeral_core.sv
tb/sv/integer_to_roman_numeral_core_tb.sv
